// ----- rtl/pcoc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcoc_pkg
// Shared types and constants of the pair-channel odd-cycle checker.
// ----------------------------------------------------------------------------
package pcoc_pkg;

    localparam int ORDER_DEFAULT = 10;
    localparam int POINT_W       = 4;

    localparam logic [1:0] FAULT_NONE      = 2'd0;
    localparam logic [1:0] FAULT_COLLISION = 2'd1;
    localparam logic [1:0] FAULT_WALK      = 2'd2;
    localparam logic [1:0] FAULT_NOT_PERM  = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREP,
        ST_WALK,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic load;
        logic init;
        logic step;
        logic finish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic perm;
        logic pop;
        logic out_busy;
    } dp_stat_t;

    typedef struct packed {
        logic init;
        logic step;
        logic set;
        logic clr;
    } lane_cmd_t;

endpackage

// ----- rtl/pcoc_lane.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcoc_lane
// One partial map with its link check and walk unit.
// ----------------------------------------------------------------------------
module pcoc_lane
    import pcoc_pkg::*;
#(
    parameter int ORDER = ORDER_DEFAULT
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  lane_cmd_t          cmd,
    input  logic [POINT_W-1:0] src,
    input  logic [POINT_W-1:0] dst,
    output logic [1:0]         fault,
    output logic               odd
);

    localparam int IW = (ORDER > 1) ? $clog2(ORDER) : 1;
    localparam int LW = $clog2(ORDER + 1);
    localparam logic [POINT_W:0] ORDER_P = (POINT_W + 1)'(ORDER);
    localparam logic [LW-1:0]    ORDER_L = LW'(ORDER);

    logic [POINT_W:0]   map_reg [ORDER];
    logic [POINT_W-1:0] cur_reg, cur_next;
    logic [LW-1:0]      len_reg, len_next;
    logic               act_reg, act_next;
    logic [1:0]         fault_reg, fault_next;
    logic               odd_reg, odd_next;
    logic [POINT_W-1:0] rd_addr;
    logic [POINT_W:0]   rd;

    assign rd_addr = cmd.init ? src : cur_reg;
    assign rd      = map_reg[rd_addr[IW-1:0]];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ORDER; i++)
            begin
                map_reg[i] <= '0;
            end
        end
        else if (cmd.set)
        begin
            map_reg[src[IW-1:0]] <= {1'b1, dst};
        end
        else if (cmd.clr)
        begin
            map_reg[src[IW-1:0]] <= '0;
        end
    end

    always_comb
    begin
        cur_next   = cur_reg;
        len_next   = len_reg;
        act_next   = act_reg;
        fault_next = fault_reg;
        odd_next   = odd_reg;
        if (cmd.init)
        begin
            cur_next   = dst;
            len_next   = LW'(1);
            odd_next   = 1'b0;
            act_next   = !rd[POINT_W];
            fault_next = rd[POINT_W] ? FAULT_COLLISION : FAULT_NONE;
        end
        else if (cmd.step && act_reg)
        begin
            if ((cur_reg == src) || !rd[POINT_W])
            begin
                act_next = 1'b0;
                odd_next = (cur_reg == src) && len_reg[0];
            end
            else if (({1'b0, rd[POINT_W-1:0]} >= ORDER_P) || (len_reg >= ORDER_L))
            begin
                act_next   = 1'b0;
                fault_next = FAULT_WALK;
            end
            else
            begin
                cur_next = rd[POINT_W-1:0];
                len_next = len_reg + LW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg   <= '0;
            len_reg   <= '0;
            act_reg   <= 1'b0;
            fault_reg <= FAULT_NONE;
            odd_reg   <= 1'b0;
        end
        else
        begin
            cur_reg   <= cur_next;
            len_reg   <= len_next;
            act_reg   <= act_next;
            fault_reg <= fault_next;
            odd_reg   <= odd_next;
        end
    end

    assign fault = fault_reg;
    assign odd   = odd_reg;

endmodule

// ----- rtl/pcoc_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcoc_datapath
// Row register, permutation check, lane banks and result register.
// ----------------------------------------------------------------------------
module pcoc_datapath
    import pcoc_pkg::*;
#(
    parameter int ORDER = ORDER_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  ctrl_cmd_t              cmd,
    output dp_stat_t               stat,
    input  logic                   in_pop,
    input  logic [ORDER*POINT_W-1:0] in_row,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   out_no_odd,
    output logic [1:0]             out_fault
);

    localparam int PAIRS = ORDER * (ORDER - 1) / 2;

    logic [POINT_W-1:0] row_reg [ORDER];
    logic [POINT_W-1:0] inv_reg [ORDER];
    logic [POINT_W-1:0] row_c   [ORDER];
    logic [POINT_W-1:0] inv_c   [ORDER];
    logic               perm_c, perm_reg, pop_reg;
    logic [1:0]         col_fault [PAIRS];
    logic [1:0]         sym_fault [PAIRS];
    logic [PAIRS-1:0]   col_odd, sym_odd;
    logic [1:0]         first_fault;
    logic               push_ok;
    lane_cmd_t          lcmd;
    logic               out_valid_reg, no_odd_reg;
    logic [1:0]         fault_reg;

    always_comb
    begin
        perm_c = 1'b1;
        for (int i = 0; i < ORDER; i++)
        begin
            row_c[i] = in_row[i*POINT_W +: POINT_W];
            inv_c[i] = '0;
        end
        for (int i = 0; i < ORDER; i++)
        begin
            if ({1'b0, row_c[i]} >= (POINT_W + 1)'(ORDER))
            begin
                perm_c = 1'b0;
            end
            for (int j = i + 1; j < ORDER; j++)
            begin
                if (row_c[i] == row_c[j])
                begin
                    perm_c = 1'b0;
                end
            end
        end
        for (int v = 0; v < ORDER; v++)
        begin
            for (int i = 0; i < ORDER; i++)
            begin
                if (row_c[i] == POINT_W'(v))
                begin
                    inv_c[v] = POINT_W'(i);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            for (int i = 0; i < ORDER; i++)
            begin
                row_reg[i] <= row_c[i];
                inv_reg[i] <= inv_c[i];
            end
            perm_reg <= perm_c;
            pop_reg  <= in_pop;
        end
    end

    always_comb
    begin
        first_fault = FAULT_NONE;
        for (int k = PAIRS - 1; k >= 0; k--)
        begin
            if (sym_fault[k] != FAULT_NONE)
            begin
                first_fault = sym_fault[k];
            end
            if (col_fault[k] != FAULT_NONE)
            begin
                first_fault = col_fault[k];
            end
        end
    end

    assign push_ok   = perm_reg && !pop_reg && (first_fault == FAULT_NONE);
    assign lcmd.init = cmd.init;
    assign lcmd.step = cmd.step;
    assign lcmd.set  = cmd.finish && push_ok;
    assign lcmd.clr  = cmd.finish && perm_reg && pop_reg;

    for (genvar l = 0; l < ORDER; l++)
    begin : g_left
        for (genvar r = l + 1; r < ORDER; r++)
        begin : g_right
            localparam int K = l * ORDER - (l * (l + 1)) / 2 + (r - l - 1);
            pcoc_lane #(.ORDER(ORDER)) u_col (
                .clk   (clk),
                .rst_n (rst_n),
                .cmd   (lcmd),
                .src   (row_reg[l]),
                .dst   (row_reg[r]),
                .fault (col_fault[K]),
                .odd   (col_odd[K])
            );
            pcoc_lane #(.ORDER(ORDER)) u_sym (
                .clk   (clk),
                .rst_n (rst_n),
                .cmd   (lcmd),
                .src   (inv_reg[l]),
                .dst   (inv_reg[r]),
                .fault (sym_fault[K]),
                .odd   (sym_odd[K])
            );
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            if (!perm_reg)
            begin
                no_odd_reg <= pop_reg;
                fault_reg  <= FAULT_NOT_PERM;
            end
            else if (pop_reg)
            begin
                no_odd_reg <= 1'b1;
                fault_reg  <= FAULT_NONE;
            end
            else
            begin
                no_odd_reg <= push_ok && !(|col_odd) && !(|sym_odd);
                fault_reg  <= first_fault;
            end
        end
    end

    assign stat.perm     = perm_reg;
    assign stat.pop      = pop_reg;
    assign stat.out_busy = out_valid_reg && !out_ready;
    assign out_valid     = out_valid_reg;
    assign out_no_odd    = no_odd_reg;
    assign out_fault     = fault_reg;

endmodule

// ----- rtl/pcoc_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcoc_ctrl
// Sequencer for load, link check, walk and result of one item.
// ----------------------------------------------------------------------------
module pcoc_ctrl
    import pcoc_pkg::*;
#(
    parameter int ORDER = ORDER_DEFAULT
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  dp_stat_t  stat,
    output ctrl_cmd_t cmd
);

    localparam int CW = $clog2(ORDER + 1);
    localparam logic [CW-1:0] LAST = CW'(ORDER - 1);

    state_t        state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                cnt_next   = '0;
                state_next = (!stat.perm || stat.pop) ? ST_FINISH : ST_WALK;
            end
            ST_WALK:
            begin
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == LAST)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!stat.out_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_PREP:
            begin
                cmd.init = stat.perm && !stat.pop;
            end
            ST_WALK:
            begin
                cmd.step = 1'b1;
            end
            ST_FINISH:
            begin
                cmd.finish = !stat.out_busy;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

// ----- rtl/pair_channel_odd_cycle_check_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pair_channel_odd_cycle_check_core
// Pushes and pops permutation rows into column and symbol pair maps and
// reports odd cycles closed by a push.
// ----------------------------------------------------------------------------
// Channel  Direction  Content
// s_*      in         tuser: command; tdata: entry_0 .. entry_(ORDER-1)
// m_*      out        tdata: no_odd_cycle, fault
//
// A push runs a link check and then a walk that all lanes run together
// before its result is presented; a pop or a row that is not a permutation
// skips the walk. The next item can be taken in the same cycle in which
// the result is presented.
// Reset clears every map at once. A stalled result holds the last cycle.
// ----------------------------------------------------------------------------
module pair_channel_odd_cycle_check_core
    import pcoc_pkg::*;
#(
    parameter int ORDER = ORDER_DEFAULT
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // Fields from bit 0: entry_0, entry_1, ... entry_(ORDER-1), zero fill.
    input  logic [((ORDER*POINT_W+7)/8)*8-1:0] s_tdata,
    // Fields from bit 0: command.
    input  logic                               s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // Fields from bit 0: no_odd_cycle, fault, zero fill.
    output logic [7:0]                         m_tdata
);

    ctrl_cmd_t  cmd;
    dp_stat_t   stat;
    logic       no_odd;
    logic [1:0] fault;

    pcoc_ctrl #(.ORDER(ORDER)) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    pcoc_datapath #(.ORDER(ORDER)) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .in_pop     (s_tuser),
        .in_row     (s_tdata[ORDER*POINT_W-1:0]),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_no_odd (no_odd),
        .out_fault  (fault)
    );

    assign m_tdata = {5'b0, fault, no_odd};

endmodule

// ----- rtl/pcoc_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcoc_checker
// Port-level checks of the odd-cycle checker, bound to the top level.
// ----------------------------------------------------------------------------
module pcoc_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("item taken while one is in work");

    a_fault_clears_flag: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[2:1] == 2'd1 || m_tdata[2:1] == 2'd2) |-> !m_tdata[0])
        else $error("push fault reported with no odd cycle set");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[7:3] == 5'd0)
        else $error("result padding not zero");

endmodule

bind pair_channel_odd_cycle_check_core pcoc_checker u_pcoc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ----- tb/pair_channel_odd_cycle_check_core_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pair_channel_odd_cycle_check_core_test
// Drives push and pop rows into the odd-cycle checker under random bursts
// and output stalls, and compares each result with a local prediction of
// the column and symbol pair maps.
// ----------------------------------------------------------------------------
module pair_channel_odd_cycle_check_core_test;
    import pcoc_pkg::*;

    localparam int N      = 10;
    localparam int NPAIR  = N * (N - 1) / 2;
    localparam int DW     = ((N * POINT_W + 7) / 8) * 8;
    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic       no_odd;
        logic [1:0] fault;
    } verdict_t;

    typedef logic [3:0] row_t [N];

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          s_tvalid = 1'b0;
    logic          s_tready;
    logic [DW-1:0] s_tdata = '0;
    logic          s_tuser = 1'b0;
    logic          m_tvalid;
    logic          m_tready = 1'b0;
    logic [7:0]    m_tdata;

    logic [4:0] col_map [NPAIR][N];
    logic [4:0] sym_map [NPAIR][N];
    verdict_t   pending_verdicts [$];
    int         errors = 0;
    int         cycles = 0;
    int         burst_left = 0;
    row_t       live_rows [$];

    pair_channel_odd_cycle_check_core u_top (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Receiver stalls in a pattern: long open stretches, then choppy phases.
    always @(posedge clk)
    begin
        if (((cycles / 300) % 3) == 0)
            m_tready <= 1'b1;
        else
            m_tready <= ($urandom_range(0, 3) != 0);
    end

    always @(posedge clk)
    begin
        verdict_t got, want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.no_odd = m_tdata[0];
            got.fault  = m_tdata[2:1];
            if (pending_verdicts.size() == 0)
            begin
                $display("%0t: unexpected result %b", $time, got);
                errors++;
            end
            else
            begin
                want = pending_verdicts.pop_front();
                if (got.no_odd !== want.no_odd)
                begin
                    $display("%0t: no_odd_cycle expected %b actual %b", $time,
                             want.no_odd, got.no_odd);
                    errors++;
                end
                if (got.fault !== want.fault)
                begin
                    $display("%0t: fault expected %0d actual %0d", $time,
                             want.fault, got.fault);
                    errors++;
                end
                if (m_tdata[7:3] !== '0)
                begin
                    $display("%0t: fill expected 0 actual %b", $time, m_tdata[7:3]);
                    errors++;
                end
            end
        end
    end

    function automatic logic [1:0] add_link(ref logic [4:0] lane [N], input int src,
                                            input int dst, ref logic odd);
        int len;
        int cur;
        len = 1;
        cur = dst;
        if (lane[src][4])
            return FAULT_COLLISION;
        lane[src] = {1'b1, 4'(dst)};
        while (cur != src && lane[cur][4])
        begin
            cur = lane[cur][3:0];
            if (cur >= N)
                return FAULT_WALK;
            len++;
            if (len > N)
                return FAULT_WALK;
        end
        if (cur == src && len[0])
            odd = 1'b1;
        return FAULT_NONE;
    endfunction

    function automatic verdict_t predict_row(logic cmd, row_t row);
        logic [4:0] col_try [NPAIR][N];
        logic [4:0] sym_try [NPAIR][N];
        int   inv [N];
        bit   seen [N];
        bit   perm;
        logic odd;
        logic [1:0] f;
        int   ch;
        perm = 1;
        odd = 1'b0;
        f = FAULT_NONE;
        ch = 0;
        foreach (seen[i]) seen[i] = 0;
        foreach (inv[i]) inv[i] = 0;
        for (int i = 0; i < N; i++)
        begin
            if (row[i] >= N || seen[row[i]])
                perm = 0;
            else
            begin
                seen[row[i]] = 1;
                inv[row[i]] = i;
            end
        end
        if (!perm)
            return '{no_odd: cmd, fault: FAULT_NOT_PERM};
        if (cmd == CMD_POP)
        begin
            for (int l = 0; l < N; l++)
                for (int r = l + 1; r < N; r++)
                begin
                    col_map[ch][row[l]] = '0;
                    sym_map[ch][inv[l]] = '0;
                    ch++;
                end
            return '{no_odd: 1'b1, fault: FAULT_NONE};
        end
        col_try = col_map;
        sym_try = sym_map;
        for (int l = 0; l < N && f == FAULT_NONE; l++)
            for (int r = l + 1; r < N && f == FAULT_NONE; r++)
            begin
                f = add_link(col_try[ch], row[l], row[r], odd);
                if (f == FAULT_NONE)
                    f = add_link(sym_try[ch], inv[l], inv[r], odd);
                ch++;
            end
        if (f != FAULT_NONE)
            return '{no_odd: 1'b0, fault: f};
        col_map = col_try;
        sym_map = sym_try;
        return '{no_odd: !odd, fault: FAULT_NONE};
    endfunction

    task automatic send_row(logic cmd, row_t row);
        logic [DW-1:0] packed_row;
        verdict_t      v;
        packed_row = '0;
        for (int i = 0; i < N; i++)
            packed_row[i*POINT_W +: POINT_W] = row[i];
        if (burst_left == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= packed_row;
        s_tuser  <= cmd;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        v = predict_row(cmd, row);
        pending_verdicts.insert(pending_verdicts.size(), v);
        if (cmd == CMD_PUSH && v.fault == FAULT_NONE)
            live_rows.insert(live_rows.size(), row);
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_verdicts.size() != 0) @(posedge clk);
    endtask

    function automatic row_t shuffled_row();
        row_t r;
        int j;
        logic [3:0] t;
        for (int i = 0; i < N; i++) r[i] = 4'(i);
        for (int i = N - 1; i > 0; i--)
        begin
            j = $urandom_range(0, i);
            t = r[i]; r[i] = r[j]; r[j] = t;
        end
        return r;
    endfunction

    function automatic row_t identity_row();
        row_t r;
        for (int i = 0; i < N; i++) r[i] = 4'(i);
        return r;
    endfunction

    task automatic test_directed;
        row_t r;
        r = identity_row();
        send_row(CMD_PUSH, r);
        send_row(CMD_PUSH, r);
        for (int i = 0; i < N; i++) r[i] = 4'(N - 1 - i);
        send_row(CMD_PUSH, r);
        r = identity_row();
        r[3] = 4'hF;
        send_row(CMD_PUSH, r);
        send_row(CMD_POP, r);
        r = identity_row();
        r[5] = r[6];
        send_row(CMD_PUSH, r);
        r = identity_row();
        send_row(CMD_POP, r);
        for (int i = 0; i < N; i++) r[i] = 4'(N - 1 - i);
        send_row(CMD_POP, r);
        send_row(CMD_POP, r);
        for (int i = 0; i < N; i++) r[i] = 4'((i + 1) % N);
        send_row(CMD_PUSH, r);
        for (int i = 0; i < N; i++) r[i] = 4'((i + 2) % N);
        send_row(CMD_PUSH, r);
        for (int i = 0; i < N; i++) r[i] = 4'((i + 9) % N);
        send_row(CMD_PUSH, r);
        r = '{default: 4'hF};
        send_row(CMD_PUSH, r);
        drain();
    endtask

    task automatic test_random(int count);
        row_t r;
        int k;
        for (int n = 0; n < count; n++)
        begin
            k = $urandom_range(0, 9);
            if (k < 5 || live_rows.size() == 0)
                send_row(CMD_PUSH, shuffled_row());
            else if (k < 8)
            begin
                r = live_rows[$urandom_range(0, live_rows.size() - 1)];
                send_row(CMD_POP, r);
            end
            else if (k == 8)
            begin
                r = shuffled_row();
                r[$urandom_range(0, N - 1)] = 4'($urandom_range(0, 15));
                send_row(1'($urandom_range(0, 1)), r);
            end
            else
            begin
                foreach (r[i]) r[i] = 4'($urandom_range(0, 15));
                send_row(1'($urandom_range(0, 1)), r);
            end
            if (live_rows.size() > 6)
                void'(live_rows.pop_front());
            if (n % 150 == 75)
                drain();
        end
    endtask

    initial
    begin
        foreach (col_map[p, i]) col_map[p][i] = '0;
        foreach (sym_map[p, i]) sym_map[p][i] = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(740);
        drain();
        repeat (40) @(posedge clk);
        if (errors == 0 && pending_verdicts.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
